// ===== design/srls_pkg.sv =====
// ----------------------------------------------------------------------------
// srls_pkg: shared types and constants
// Field widths, fixed-point constants and defaults for the stereo RMS
// level smoother.
// ----------------------------------------------------------------------------
package srls_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 40;
    localparam int RMS_W      = 16;
    localparam int LEVEL_W    = 24;
    localparam int SENS_W     = 16;
    localparam int SENS_FRAC  = 12;
    localparam int DECAY_FRAC = 16;

    localparam int MAX_FRAMES_DEFAULT = 256;

    // 0.93 in Q0.16.
    localparam logic [DECAY_FRAC-1:0] DECAY_Q16 = 16'd60948;

    // 1.0 in Q4.12.
    localparam logic [SENS_W-1:0] SENS_RESET = 16'd4096;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]           sum_t;
    typedef logic [RMS_W-1:0]           rms_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic [SENS_W-1:0]          sens_t;

endpackage

// ===== design/srls_if.sv =====
// ----------------------------------------------------------------------------
// srls_if: stream interfaces
// Valid/ready channels for the frame input and the result output.
// ----------------------------------------------------------------------------
interface srls_in_if;
    logic              valid;
    logic              ready;
    srls_pkg::sample_t left_sample;
    srls_pkg::sample_t right_sample;
    logic              block_last;

    modport source (output valid, output left_sample, output right_sample,
                    output block_last, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_last, output ready);
endinterface

interface srls_out_if;
    logic             valid;
    logic             ready;
    srls_pkg::rms_t   block_rms;
    srls_pkg::level_t smoothed_level;

    modport source (output valid, output block_rms, output smoothed_level,
                    input ready);
    modport sink   (input valid, input block_rms, input smoothed_level,
                    output ready);
endinterface

// ===== design/stereo_rms_level_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_rms_level_smoother_unit: block RMS meter with exponential smoothing
// Accumulates squared stereo samples per block, then computes the block RMS
// and the smoothed Q9.15 level with bit-serial arithmetic units.
// ----------------------------------------------------------------------------
// Each frame item is taken and then squared bit by bit by two 16-step
// shift-and-add squarings; the input is not ready again until both have
// finished. A frame that closes a block, either by block_last or by reaching
// MAX_FRAMES frames, then also needs a 40-step divide by twice the frame
// count, a 20-step square root and a 16-step multiply for the level update;
// the input stays not ready through these as well. The result item goes to
// an output register, so the next block can stream in while it waits to be
// taken; only the next block closure waits for that register to drain.
// The sensitivity register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module stereo_rms_level_smoother_unit #(
    parameter int MAX_FRAMES = srls_pkg::MAX_FRAMES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    srls_in_if.sink           frame_in,
    srls_out_if.source        result_out,
    input  logic              sens_we,
    input  srls_pkg::sens_t   sens_wdata
);
    // The frame counter must hold MAX_FRAMES itself; the divisor is twice it.
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int DIV_W  = CNT_W + 1;
    localparam int ROOT_W = srls_pkg::SUM_W / 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;
    srls_pkg::sens_t   sens_reg;
    srls_pkg::level_t  level_reg, level_next;
    srls_pkg::rms_t    rms_reg, rms_next;
    logic              out_valid_reg, out_valid_next;
    srls_pkg::rms_t    out_rms_reg;
    srls_pkg::level_t  out_level_reg;

    logic              accept;
    logic [CNT_W-1:0]  count_inc;
    logic              out_free;
    logic              load_out;
    logic              acc_start;
    logic              acc_clear;
    logic              acc_done;
    srls_pkg::sum_t    acc_sum;

    logic              div_start;
    logic              div_done;
    logic              sqrt_start;
    logic              sqrt_done;
    logic              scale_start;
    logic              scale_done;

    srls_pkg::sum_t    quotient;
    logic [ROOT_W-1:0] root;
    srls_pkg::rms_t    rms_sat;
    srls_pkg::level_t  scale_level;

    assign frame_in.ready = (state_reg == S_IDLE);
    assign accept         = frame_in.valid && frame_in.ready;
    assign count_inc      = count_reg + 1'b1;
    assign out_free       = !out_valid_reg || result_out.ready;
    assign load_out       = (state_reg == S_WAIT) && out_free;

    // The root never exceeds 2^15 here, but the clamp keeps the field honest.
    // The level update takes the clamped root directly as the root finishes.
    assign rms_sat = (|root[ROOT_W-1:srls_pkg::RMS_W]) ? '1 : root[srls_pkg::RMS_W-1:0];

    // ------------------------------------------------------------------------
    // Block sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        level_next     = level_reg;
        rms_next       = rms_reg;
        out_valid_next = out_valid_reg;
        acc_start      = 1'b0;
        acc_clear      = 1'b0;
        div_start      = 1'b0;
        sqrt_start     = 1'b0;
        scale_start    = 1'b0;

        if (result_out.valid && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_start  = 1'b1;
                    count_next = count_inc;
                    // A block that reaches its frame limit closes on that frame.
                    last_next  = frame_in.block_last || (count_inc >= CNT_W'(MAX_FRAMES));
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_done)
                begin
                    if (last_reg)
                    begin
                        // The divider samples the sum and count on this edge,
                        // so the accumulator can be cleared at the same time.
                        div_start  = 1'b1;
                        acc_clear  = 1'b1;
                        count_next = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    scale_start = 1'b1;
                    rms_next    = rms_sat;
                    state_next  = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (scale_done)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // Hold the finished result until the output register is free.
                if (out_free)
                begin
                    level_next     = scale_level;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            sens_reg      <= srls_pkg::SENS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
            if (sens_we)
            begin
                sens_reg <= sens_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rms_reg <= rms_next;
        if (load_out)
        begin
            out_rms_reg   <= rms_reg;
            out_level_reg <= scale_level;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.block_rms      = out_rms_reg;
    assign result_out.smoothed_level = out_level_reg;

    // ------------------------------------------------------------------------
    // Serial arithmetic units
    // ------------------------------------------------------------------------
    srls_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (acc_start),
        .clear        (acc_clear),
        .left_sample  (frame_in.left_sample),
        .right_sample (frame_in.right_sample),
        .done         (acc_done),
        .sum          (acc_sum)
    );

    srls_div #(
        .N_W (srls_pkg::SUM_W),
        .D_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  ({count_reg, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    srls_sqrt #(
        .RAD_W (srls_pkg::SUM_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (quotient),
        .done     (sqrt_done),
        .root     (root)
    );

    srls_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scale_start),
        .level       (level_reg),
        .sensitivity (sens_reg),
        .rms         (rms_sat),
        .done        (scale_done),
        .level_next  (scale_level)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // An accepted frame always starts the accumulator in the next cycle.
    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ACC))
        else $error("accepted frame did not start accumulation");

    // Between frames the count stays below the block limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg < CNT_W'(MAX_FRAMES)))
        else $error("frame count reached the block limit while idle");

    // The smoothed level changes only when a result is committed.
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load_out |=> $stable(level_reg))
        else $error("level changed outside a result commit");

    // A new result appears only after the update finished.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_WAIT))
        else $error("result raised outside the commit state");

    // The mean square of signed Q1.15 samples bounds the RMS at 2^15.
    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.block_rms <= 16'd32768))
        else $error("block RMS out of range");

endmodule

// ===== design/srls_accum.sv =====
// ----------------------------------------------------------------------------
// srls_accum: serial square accumulator
// Squares both samples of a frame by shift-and-add, one multiplier bit per
// cycle, and adds each partial product into the saturating block sum.
// ----------------------------------------------------------------------------
module srls_accum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    clear,
    input  srls_pkg::sample_t       left_sample,
    input  srls_pkg::sample_t       right_sample,
    output logic                    done,
    output srls_pkg::sum_t          sum
);
    localparam int SW     = srls_pkg::SAMPLE_W;
    localparam int PROD_W = 2 * SW;
    localparam int STEP_W = $clog2(SW);

    logic              busy_reg, busy_next;
    logic              phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [SW-1:0]     mplier_reg, mplier_next;
    logic [SW-1:0]     second_reg, second_next;
    srls_pkg::sum_t    sum_reg, sum_next;

    logic [SW-1:0]                left_mag;
    logic [SW-1:0]                right_mag;
    logic [srls_pkg::SUM_W:0]     sum_add;

    // A full-scale negative sample has magnitude 2^15, which still fits.
    assign left_mag  = left_sample[SW-1]  ? (~$unsigned(left_sample) + 1'b1)
                                          : $unsigned(left_sample);
    assign right_mag = right_sample[SW-1] ? (~$unsigned(right_sample) + 1'b1)
                                          : $unsigned(right_sample);

    assign sum_add = {1'b0, sum_reg}
                   + {{(srls_pkg::SUM_W - PROD_W + 1){1'b0}}, mcand_reg};

    always_comb
    begin
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        second_next = second_reg;
        sum_next    = sum_reg;

        if (clear)
        begin
            sum_next = '0;
        end

        if (start)
        begin
            busy_next   = 1'b1;
            phase_next  = 1'b0;
            step_next   = '0;
            mcand_next  = {{(PROD_W - SW){1'b0}}, left_mag};
            mplier_next = left_mag;
            second_next = right_mag;
        end
        else if (busy_reg)
        begin
            // Saturation per partial product equals saturation per sample,
            // since every addend is non-negative.
            if (mplier_reg[0])
            begin
                sum_next = sum_add[srls_pkg::SUM_W] ? '1
                                                    : sum_add[srls_pkg::SUM_W-1:0];
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[SW-1:1]};
            step_next   = step_reg + 1'b1;
            if (step_reg == STEP_W'(SW - 1))
            begin
                step_next = '0;
                if (!phase_reg)
                begin
                    phase_next  = 1'b1;
                    mcand_next  = {{(PROD_W - SW){1'b0}}, second_reg};
                    mplier_next = second_reg;
                end
                else
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        second_reg <= second_next;
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ===== design/srls_div.sv =====
// ----------------------------------------------------------------------------
// srls_div: serial restoring divider
// Produces one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module srls_div #(
    parameter int N_W = 40,
    parameter int D_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [N_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    output logic             done,
    output logic [N_W-1:0]   quotient
);
    localparam int STEP_W = $clog2(N_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [N_W-1:0]    quo_reg, quo_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    div_reg, div_next;

    logic [D_W:0]      shifted;
    logic [D_W:0]      diff;

    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so D_W bits hold it.
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/srls_sqrt.sv =====
// ----------------------------------------------------------------------------
// srls_sqrt: serial integer square root
// Restoring digit-by-digit root, two radicand bits and one root bit a cycle.
// ----------------------------------------------------------------------------
module srls_sqrt #(
    parameter int RAD_W = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CMP_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [CMP_W-1:0]  rem_sh;
    logic [CMP_W-1:0]  trial;
    logic [CMP_W-1:0]  diff;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            // The remainder never exceeds twice the root, so REM_W bits hold it.
            if (rem_sh >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== design/srls_scale.sv =====
// ----------------------------------------------------------------------------
// srls_scale: serial level update
// Forms level*0.93 and sensitivity*rms by shift-and-add, one bit a cycle,
// then sums and saturates them into the new Q9.15 level.
// ----------------------------------------------------------------------------
module srls_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  srls_pkg::level_t     level,
    input  srls_pkg::sens_t      sensitivity,
    input  srls_pkg::rms_t       rms,
    output logic                 done,
    output srls_pkg::level_t     level_next
);
    localparam int LW     = srls_pkg::LEVEL_W;
    localparam int DW     = srls_pkg::DECAY_FRAC;
    localparam int SW     = srls_pkg::SENS_W;
    localparam int RW     = srls_pkg::RMS_W;
    localparam int PD_W   = LW + DW;
    localparam int PG_W   = SW + RW;
    localparam int GAIN_W = PG_W - srls_pkg::SENS_FRAC;
    localparam int STEP_W = $clog2(DW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PD_W-1:0]   lvl_sh_reg, lvl_sh_next;
    logic [PG_W-1:0]   sens_sh_reg, sens_sh_next;
    logic [DW-1:0]     dec_bits_reg, dec_bits_next;
    logic [RW-1:0]     rms_bits_reg, rms_bits_next;
    logic [PD_W-1:0]   pd_reg, pd_next;
    logic [PG_W-1:0]   pg_reg, pg_next;

    logic [LW:0]       total;

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        step_next     = step_reg;
        lvl_sh_next   = lvl_sh_reg;
        sens_sh_next  = sens_sh_reg;
        dec_bits_next = dec_bits_reg;
        rms_bits_next = rms_bits_reg;
        pd_next       = pd_reg;
        pg_next       = pg_reg;

        if (start)
        begin
            busy_next     = 1'b1;
            step_next     = '0;
            lvl_sh_next   = {{DW{1'b0}}, level};
            sens_sh_next  = {{RW{1'b0}}, sensitivity};
            dec_bits_next = srls_pkg::DECAY_Q16;
            rms_bits_next = rms;
            pd_next       = '0;
            pg_next       = '0;
        end
        else if (busy_reg)
        begin
            if (dec_bits_reg[0])
            begin
                pd_next = pd_reg + lvl_sh_reg;
            end
            if (rms_bits_reg[0])
            begin
                pg_next = pg_reg + sens_sh_reg;
            end
            lvl_sh_next   = {lvl_sh_reg[PD_W-2:0], 1'b0};
            sens_sh_next  = {sens_sh_reg[PG_W-2:0], 1'b0};
            dec_bits_next = {1'b0, dec_bits_reg[DW-1:1]};
            rms_bits_next = {1'b0, rms_bits_reg[RW-1:1]};
            step_next     = step_reg + 1'b1;
            if (step_reg == STEP_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_sh_reg   <= lvl_sh_next;
        sens_sh_reg  <= sens_sh_next;
        dec_bits_reg <= dec_bits_next;
        rms_bits_reg <= rms_bits_next;
        pd_reg       <= pd_next;
        pg_reg       <= pg_next;
    end

    assign total = {1'b0, pd_reg[PD_W-1:DW]}
                 + {{(LW + 1 - GAIN_W){1'b0}}, pg_reg[PG_W-1:srls_pkg::SENS_FRAC]};

    assign done       = done_reg;
    assign level_next = total[LW] ? '1 : total[LW-1:0];

endmodule

// ===== sim/tb_stereo_rms_level_smoother_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_rms_level_smoother_unit: self-checking bench for the RMS meter
// Streams stereo frames through the level smoother and predicts every block
// reading (block RMS and smoothed level) with an independent fixed-point
// model. A directed table comes first, then random blocks under several
// sensitivity settings, random stalls on both channels and back-pressure.
// ----------------------------------------------------------------------------
module tb_stereo_rms_level_smoother_unit;

    import srls_pkg::*;

    // Bench timing and stimulus sizes.
    localparam int FRAME_LIMIT    = MAX_FRAMES_DEFAULT;
    localparam int TALLY_W        = 13;
    localparam int IDLE_PCT       = 13;
    localparam int SETTLE_CYCLES  = 150;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_TRIGGER   = 25;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT    = 5;
    localparam int PHASE_ITEMS    = 230;
    localparam int DIRECTED_ROWS  = 22;

    localparam longint unsigned SUM_CAP   = (64'd1 << SUM_W) - 64'd1;
    localparam longint unsigned LEVEL_CAP = (64'd1 << LEVEL_W) - 64'd1;

    localparam sample_t S_MIN = 16'sh8000;
    localparam sample_t S_MAX = 16'sh7FFF;

    // A directed row is either one frame item or a write of the sensitivity
    // register. Frame rows whose reading is obvious carry it typed in.
    typedef enum logic {
        ROW_FRAME,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        sample_t   left;
        sample_t   right;
        logic      last;
        sens_t     sens;
        logic      typed;
        rms_t      exp_rms;
        level_t    exp_level;
    } row_t;

    typedef struct packed {
        rms_t   rms;
        level_t level;
    } reading_t;

    // Row order matters: the typed readings assume the level right after
    // reset, and later rows see the level left over by earlier blocks.
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        // Silence straight after reset: zero RMS, zero level.
        '{ROW_FRAME, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b1, 16'd0, 24'd0},
        // Full negative scale on both channels: RMS of 1.0, unity gain.
        '{ROW_FRAME, S_MIN, S_MIN, 1'b1, 16'd0, 1'b1, 16'd32768, 24'd32768},
        '{ROW_FRAME, S_MAX, S_MIN, 1'b0, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sd1, -16'sd1, 1'b0, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, -16'sd1, 16'sd1, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sh5555, 16'shAAAA, 1'b0, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'shAAAA, 16'sh5555, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        // Zero gain: the level can only decay.
        '{ROW_CFG, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, S_MIN, S_MIN, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        // Largest gain with full-scale blocks drives the level up hard.
        '{ROW_CFG, 16'sd0, 16'sd0, 1'b0, 16'hFFFF, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, S_MAX, S_MAX, 1'b0, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, S_MIN, S_MIN, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, S_MIN, S_MAX, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sd1, 16'sd0, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        // Smallest nonzero gain.
        '{ROW_CFG, 16'sd0, 16'sd0, 1'b0, 16'd1, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sd30000, -16'sd30000, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_CFG, 16'sd0, 16'sd0, 1'b0, SENS_RESET, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, S_MIN, S_MAX, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, 16'sd255, -16'sd256, 1'b0, 16'd0, 1'b0, 16'd0, 24'd0},
        '{ROW_FRAME, S_MIN, 16'sd0, 1'b1, 16'd0, 1'b0, 16'd0, 24'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic sens_we;
    sens_t sens_wdata;

    srls_in_if  frame_bus ();
    srls_out_if result_bus ();

    stereo_rms_level_smoother_unit #(
        .MAX_FRAMES (FRAME_LIMIT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_bus),
        .result_out (result_bus),
        .sens_we    (sens_we),
        .sens_wdata (sens_wdata)
    );

    // Predictor state: the meter as it should stand after every accepted item.
    logic [SUM_W-1:0]   energy_acc  = '0;
    logic [TALLY_W-1:0] frame_tally = '0;
    level_t             meter_level = '0;
    sens_t              gain_q412   = SENS_RESET;

    // Readings that the block still owes, oldest first.
    reading_t expected_readings [$];

    int  errors        = 0;
    int  readings_seen = 0;
    int  quiet_cycles  = 0;
    bit  calm          = 1'b0;
    bit  hold_off      = 1'b0;

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Integer square root by setting result bits from the top down. The mean
    // never exceeds 2^30, so a 17-bit search is wide enough.
    function automatic rms_t int_root(input longint unsigned value);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        if (root > 64'hFFFF)
            root = 64'hFFFF;
        return rms_t'(root);
    endfunction

    // Takes one frame into the predicted meter. When the frame closes a
    // block, either by its last flag or by filling the block to the frame
    // limit, the block reading is returned and the accumulator cleared.
    task automatic advance_meter(input sample_t left, input sample_t right,
                                 input logic last, output bit closed,
                                 output reading_t reading);
        longint          left_wide;
        longint          right_wide;
        longint unsigned total;
        longint unsigned mean;
        longint unsigned decay;
        longint unsigned gain;
        longint unsigned next_level;
        rms_t            rms;
        begin
            left_wide  = left;
            right_wide = right;
            // Both squares are non-negative, so saturating once at the end
            // is the same as saturating after each addition.
            total = 64'(energy_acc) + 64'(left_wide * left_wide)
                    + 64'(right_wide * right_wide);
            if (total > SUM_CAP)
                total = SUM_CAP;
            frame_tally = frame_tally + 1'b1;
            closed  = last || (frame_tally >= FRAME_LIMIT);
            reading = '0;
            if (closed)
            begin
                mean  = total / (64'd2 * 64'(frame_tally));
                rms   = int_root(mean);
                decay = (64'(meter_level) * 64'(DECAY_Q16)) >> DECAY_FRAC;
                gain  = (64'(gain_q412) * 64'(rms)) >> SENS_FRAC;
                next_level = decay + gain;
                if (next_level > LEVEL_CAP)
                    next_level = LEVEL_CAP;
                meter_level = level_t'(next_level);
                energy_acc  = '0;
                frame_tally = '0;
                reading.rms   = rms;
                reading.level = meter_level;
            end
            else
            begin
                energy_acc = total[SUM_W-1:0];
            end
        end
    endtask

    // Offers one frame item and waits for it to be taken. Valid stays high
    // after the handshake, so back-to-back items keep the channel busy; idle
    // cycles are inserted in front of the item instead.
    task automatic send_frame(input sample_t left, input sample_t right,
                              input logic last, input logic typed,
                              input rms_t typed_rms, input level_t typed_level);
        bit       closed;
        reading_t reading;
        begin
            if (!calm)
            begin
                while ($urandom_range(99) < IDLE_PCT)
                begin
                    frame_bus.valid <= 1'b0;
                    @(posedge clk);
                end
            end
            frame_bus.valid        <= 1'b1;
            frame_bus.left_sample  <= left;
            frame_bus.right_sample <= right;
            frame_bus.block_last   <= last;
            @(posedge clk);
            while (!frame_bus.ready)
                @(posedge clk);
            advance_meter(left, right, last, closed, reading);
            if (closed)
            begin
                if (typed)
                begin
                    reading.rms   = typed_rms;
                    reading.level = typed_level;
                end
                expected_readings.insert(expected_readings.size(), reading);
            end
        end
    endtask

    // Lowers valid and waits until every owed reading has come back, then
    // lets the block finish any frame that produces no reading.
    task automatic settle();
        begin
            frame_bus.valid <= 1'b0;
            @(posedge clk);
            while (expected_readings.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // The register is only written while the block is idle.
    task automatic write_sensitivity(input sens_t value);
        begin
            sens_we    <= 1'b1;
            sens_wdata <= value;
            @(posedge clk);
            sens_we   <= 1'b0;
            gain_q412 = value;
        end
    endtask

    // Samples favor the two full-scale values and quiet signals, so that
    // both loud and near-silent blocks turn up often.
    function automatic sample_t pick_sample();
        int pick;
        int quiet;
        pick = $urandom_range(9);
        case (pick)
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3:
            begin
                quiet = int'($urandom_range(512)) - 256;
                return sample_t'(quiet);
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Most blocks are short so that many readings come back; a few are long and
    // can pass the frame limit, though the caller clips them to the phase items.
    function automatic int pick_block_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return $urandom_range(8, 1);
        else if (pick < 97)
            return $urandom_range(40, 9);
        else
            return $urandom_range(300, 200);
    endfunction

    // Streams one block of random frames with the last flag on the closing
    // frame. A noisy block also sets or clears the flag at random on any frame.
    task automatic stream_block(input int frames, input bit noisy);
        logic last;
        begin
            for (int k = 0; k < frames; k++)
            begin
                last = (k == frames - 1);
                if (noisy && $urandom_range(99) < 8)
                    last = 1'($urandom_range(1));
                send_frame(pick_sample(), pick_sample(), last, 1'b0, '0, '0);
            end
        end
    endtask

    // The receiver takes readings with random stalls, except during the calm
    // phase and during the long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            result_bus.ready <= 1'b0;
        else if (calm)
            result_bus.ready <= 1'b1;
        else
            result_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Once the stream is under way, the receiver stops taking readings for a
    // long stretch while the sender keeps offering frames. The output register
    // fills and the next block closure has to stall the frame input.
    initial
    begin
        wait (readings_seen >= HOLD_TRIGGER);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Every reading taken is checked against the oldest one owed.
    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            readings_seen++;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: reading with none owed, block_rms %0d smoothed_level %0d",
                         $time, result_bus.block_rms, result_bus.smoothed_level);
                errors++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (result_bus.block_rms !== want.rms)
                begin
                    $display("%0t: block_rms expected %0d actual %0d",
                             $time, want.rms, result_bus.block_rms);
                    errors++;
                end
                if (result_bus.smoothed_level !== want.level)
                begin
                    $display("%0t: smoothed_level expected %0d actual %0d",
                             $time, want.level, result_bus.smoothed_level);
                    errors++;
                end
            end
        end
    end

    // Any long stretch with no handshake on either channel means the block
    // has hung.
    always @(posedge clk)
    begin
        if ((frame_bus.valid && frame_bus.ready) ||
            (result_bus.valid && result_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_stereo_rms_level_smoother_unit: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int    sent;
        int    frames;
        sens_t phase_gain;

        rst_n                  = 1'b0;
        sens_we                <= 1'b0;
        sens_wdata             <= '0;
        frame_bus.valid        <= 1'b0;
        frame_bus.left_sample  <= '0;
        frame_bus.right_sample <= '0;
        frame_bus.block_last   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                settle();
                write_sensitivity(DIRECTED[i].sens);
            end
            else
            begin
                send_frame(DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].last,
                           DIRECTED[i].typed, DIRECTED[i].exp_rms,
                           DIRECTED[i].exp_level);
            end
        end

        // Random phases, each under its own gain. The drain before every
        // write also makes the sender pause until all readings are in.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       phase_gain = sens_t'($urandom);
                1:       phase_gain = 16'hFFFF;
                2:       phase_gain = 16'h0000;
                3:       phase_gain = sens_t'($urandom_range(8191));
                default: phase_gain = SENS_RESET;
            endcase
            settle();
            write_sensitivity(phase_gain);
            // The second phase runs without any idling on either side.
            calm = (p == 1);

            if (p == 0)
            begin
                // A block that never sets the last flag closes itself at the
                // frame limit and the rest of it forms a second block; then a
                // block whose last flag lands exactly on the limit.
                stream_block(FRAME_LIMIT + 44, 1'b0);
                stream_block(FRAME_LIMIT, 1'b0);
            end

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                frames = pick_block_len();
                if (frames > PHASE_ITEMS - sent)
                    frames = PHASE_ITEMS - sent;
                stream_block(frames, 1'b1);
                sent += frames;
            end
        end
        calm = 1'b0;

        // Wait for the last readings, then give the block time to show any
        // reading that nobody expects.
        frame_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_stereo_rms_level_smoother_unit: clean");
        else
            $display("tb_stereo_rms_level_smoother_unit: errors");
        $finish;
    end

endmodule
